// ===== src/qte_pkg.sv =====
// shared constants, types and the arctangent table for the quaternion to euler unit
package qte_pkg;

  localparam int QUAT_FRAC_BITS = 15;
  localparam int ANGLE_BITS     = 16;
  localparam int QW             = 16;
  localparam int VW             = 36;
  localparam int ZW             = 34;
  localparam int SQRT_STEPS     = 32;
  localparam int RAD_W          = 2 * SQRT_STEPS;
  localparam int REM_W          = SQRT_STEPS + 4;

  localparam logic signed [VW-1:0] ONE_Q  = VW'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
  localparam logic signed [VW-1:0] HALF_Q = VW'(64'sd1 <<< (2 * QUAT_FRAC_BITS - 1));
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1 <<< 30);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'sd1 <<< (31 - ANGLE_BITS));

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  // atan(2^-i), pi = 2^31
  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // fold the left half plane onto the right half plane
  function automatic vec_t prerotate(input logic signed [VW-1:0] x,
                                     input logic signed [VW-1:0] y);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = QUARTER_TURN;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -QUARTER_TURN;
      end
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  // round an internal angle to the output field
  function automatic logic [ANGLE_BITS-1:0] to_field(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = z + ROUND_HALF;
    return r[31 -: ANGLE_BITS];
  endfunction

endpackage

// ===== src/qte_sqrt_cell.sv =====
// one digit step of the pipelined integer square root
module qte_sqrt_cell import qte_pkg::*; (
  input  logic                  clk,
  input  logic [RAD_W-1:0]      rad_in,
  input  logic [REM_W-1:0]      rem_in,
  input  logic [SQRT_STEPS-1:0] root_in,
  output logic [RAD_W-1:0]      rad,
  output logic [REM_W-1:0]      rem,
  output logic [SQRT_STEPS-1:0] root
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_in, 2'b01});

  always_ff @(posedge clk) begin
    rad <= {rad_in[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem  <= rem_sh - trial;
      root <= {root_in[SQRT_STEPS-2:0], 1'b1};
    end else begin
      rem  <= rem_sh;
      root <= {root_in[SQRT_STEPS-2:0], 1'b0};
    end
  end

endmodule

// ===== src/qte_cordic_cell.sv =====
// one vectoring rotation of the cordic arctangent
module qte_cordic_cell import qte_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  vec_t v_in,
  output vec_t v
);

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_val(STAGE));

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;

  assign xs = v_in.x >>> STAGE;
  assign ys = v_in.y >>> STAGE;

  always_ff @(posedge clk) begin
    v.zero <= v_in.zero;
    if (v_in.y >= 0) begin
      v.x <= v_in.x + ys;
      v.y <= v_in.y - xs;
      v.z <= v_in.z + ANG;
    end else begin
      v.x <= v_in.x - ys;
      v.y <= v_in.y + xs;
      v.z <= v_in.z - ANG;
    end
  end

endmodule

// ===== src/quaternion_to_euler_angles_unit.sv =====
// top level: quaternion to roll, pitch and yaw angles
// throughput: one word per cycle outside reset; every stage is a register, so a new word enters each cycle
// the 32 square root cells and the cordic cells set the latency
// busy follows reset only; results cannot be stalled and appear once, marked by done
// reset (rst, synchronous) empties the valid pipe; data registers are not cleared
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [QW-1:0]  quat_w,
  input  logic signed [QW-1:0]  quat_x,
  input  logic signed [QW-1:0]  quat_y,
  input  logic signed [QW-1:0]  quat_z,
  output logic                  done,
  output logic signed [ANGLE_BITS-1:0] roll_angle,
  output logic signed [ANGLE_BITS-1:0] pitch_angle,
  output logic signed [ANGLE_BITS-1:0] yaw_angle,
  output logic                  pitch_clamped
);

  // products, sums, square root cells, fold, cordic cells, output register
  localparam int LAT = 2 + SQRT_STEPS + 1 + CORDIC_STAGES + 1;

  logic           accept;
  logic [LAT-1:0] vpipe;

  assign busy   = rst;
  assign accept = start && !busy;

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end
  assign done = vpipe[LAT-1];

  // stage 1: the nine exact products
  logic signed [2*QW-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_xz;

  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
    p_wy <= quat_w * quat_y;
    p_xz <= quat_x * quat_z;
  end

  // stage 2: atan2 operands for roll and yaw, clamped t and the pitch radicands
  logic signed [VW-1:0] roll_y_c, roll_x_c, yaw_y_c, yaw_x_c, t_raw, t_cl;
  logic signed [VW-1:0] a_c, b_c;
  logic                 clamp_c;

  always_comb begin
    roll_y_c = (VW'(p_wx) + VW'(p_yz)) <<< 1;
    roll_x_c = ONE_Q - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
    yaw_y_c  = (VW'(p_wz) + VW'(p_xy)) <<< 1;
    yaw_x_c  = ONE_Q - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
    t_raw    = VW'(p_wy) - VW'(p_xz);
    clamp_c  = 1'b0;
    t_cl     = t_raw;
    if (t_raw > HALF_Q) begin
      t_cl    = HALF_Q;
      clamp_c = 1'b1;
    end
    if (t_raw < -HALF_Q) begin
      t_cl    = -HALF_Q;
      clamp_c = 1'b1;
    end
    a_c = ONE_Q + (t_cl <<< 1);
    b_c = ONE_Q - (t_cl <<< 1);
  end

  logic signed [VW-1:0] roll_y_r, roll_x_r, yaw_y_r, yaw_x_r;
  logic [RAD_W-1:0]     rad_a, rad_b;
  logic                 clamp_r;

  // radicands carry the fixed left shift so the roots keep 16 extra bits
  always_ff @(posedge clk) begin
    roll_y_r <= roll_y_c;
    roll_x_r <= roll_x_c;
    yaw_y_r  <= yaw_y_c;
    yaw_x_r  <= yaw_x_c;
    clamp_r  <= clamp_c;
    rad_a    <= {a_c[SQRT_STEPS-1:0], {(RAD_W-SQRT_STEPS){1'b0}}};
    rad_b    <= {b_c[SQRT_STEPS-1:0], {(RAD_W-SQRT_STEPS){1'b0}}};
  end

  // square root rows: one result bit per cell
  logic [RAD_W-1:0]      ra [SQRT_STEPS+1];
  logic [REM_W-1:0]      ma [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0] qa [SQRT_STEPS+1];
  logic [RAD_W-1:0]      rb [SQRT_STEPS+1];
  logic [REM_W-1:0]      mb [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0] qb [SQRT_STEPS+1];

  assign ra[0] = rad_a;
  assign ma[0] = '0;
  assign qa[0] = '0;
  assign rb[0] = rad_b;
  assign mb[0] = '0;
  assign qb[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qte_sqrt_cell u_sa (
      .clk(clk), .rad_in(ra[i]), .rem_in(ma[i]), .root_in(qa[i]),
      .rad(ra[i+1]), .rem(ma[i+1]), .root(qa[i+1])
    );
    qte_sqrt_cell u_sb (
      .clk(clk), .rad_in(rb[i]), .rem_in(mb[i]), .root_in(qb[i]),
      .rad(rb[i+1]), .rem(mb[i+1]), .root(qb[i+1])
    );
  end

  // roll and yaw operands and the clamp flag wait for the roots
  logic signed [VW-1:0] dl_ry [SQRT_STEPS];
  logic signed [VW-1:0] dl_rx [SQRT_STEPS];
  logic signed [VW-1:0] dl_yy [SQRT_STEPS];
  logic signed [VW-1:0] dl_yx [SQRT_STEPS];
  logic                 dl_cl [SQRT_STEPS];

  always_ff @(posedge clk) begin
    dl_ry[0] <= roll_y_r;
    dl_rx[0] <= roll_x_r;
    dl_yy[0] <= yaw_y_r;
    dl_yx[0] <= yaw_x_r;
    dl_cl[0] <= clamp_r;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      dl_ry[k] <= dl_ry[k-1];
      dl_rx[k] <= dl_rx[k-1];
      dl_yy[k] <= dl_yy[k-1];
      dl_yx[k] <= dl_yx[k-1];
      dl_cl[k] <= dl_cl[k-1];
    end
  end

  // fold stage: bring every vector into the right half plane
  vec_t cr [CORDIC_STAGES+1];
  vec_t cy [CORDIC_STAGES+1];
  vec_t cp [CORDIC_STAGES+1];
  logic cl_d [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    cr[0]   <= prerotate(dl_rx[SQRT_STEPS-1], dl_ry[SQRT_STEPS-1]);
    cy[0]   <= prerotate(dl_yx[SQRT_STEPS-1], dl_yy[SQRT_STEPS-1]);
    cp[0]   <= prerotate(VW'(qb[SQRT_STEPS]), VW'(qa[SQRT_STEPS]));
    cl_d[0] <= dl_cl[SQRT_STEPS-1];
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      cl_d[k] <= cl_d[k-1];
    end
  end

  // cordic rows, three vectors side by side
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    qte_cordic_cell #(.STAGE(s)) u_cr (.clk(clk), .v_in(cr[s]), .v(cr[s+1]));
    qte_cordic_cell #(.STAGE(s)) u_cy (.clk(clk), .v_in(cy[s]), .v(cy[s+1]));
    qte_cordic_cell #(.STAGE(s)) u_cp (.clk(clk), .v_in(cp[s]), .v(cp[s+1]));
  end

  // output register: zero vector gives angle zero, pitch is twice the angle less a quarter turn
  logic signed [ZW-1:0] roll_z, yaw_z, pitch_z;

  always_comb begin
    roll_z  = cr[CORDIC_STAGES].zero ? '0 : cr[CORDIC_STAGES].z;
    yaw_z   = cy[CORDIC_STAGES].zero ? '0 : cy[CORDIC_STAGES].z;
    pitch_z = (cp[CORDIC_STAGES].z <<< 1) - QUARTER_TURN;
  end

  always_ff @(posedge clk) begin
    roll_angle    <= to_field(roll_z);
    yaw_angle     <= to_field(yaw_z);
    pitch_angle   <= to_field(pitch_z);
    pitch_clamped <= cl_d[CORDIC_STAGES];
  end

endmodule

// ===== src/qte_checker.sv =====
// port-level checks for the quaternion to euler unit, bound to the top level
module qte_checker import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic signed [ANGLE_BITS-1:0] pitch_angle
);

  localparam int LAT = 2 + SQRT_STEPS + 1 + CORDIC_STAGES + 1;

  // every accepted word gives exactly one result after the fixed latency
  a_lat : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after accepted word");

  a_no_extra : assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LAT !done)
    else $error("result without accepted word");

  a_pitch : assert property (@(posedge clk) disable iff (rst)
    done |-> pitch_angle != {1'b1, {(ANGLE_BITS-1){1'b0}}})
    else $error("pitch outside half turn");

endmodule

bind quaternion_to_euler_angles_unit qte_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_qte_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .pitch_angle(pitch_angle)
);

// ===== tb/sv/tb_top.sv =====
// testbench for the quaternion to euler angles unit: predicted angles checked per word
`timescale 1ns / 1ps

module tb_top;
  import qte_pkg::*;

  localparam int CORDIC_N   = 16;
  localparam int LATENCY    = 36 + CORDIC_N;
  localparam int CYCLE_CAP  = 1000000;
  localparam longint NORM_CAP = 64'sd1 <<< 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic done;
  logic signed [ANGLE_BITS-1:0] roll_angle, pitch_angle, yaw_angle;
  logic pitch_clamped;

  typedef struct {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        clamp;
  } angles_t;

  angles_t angles_due[$];
  int fail_count = 0;
  longint cycle_no = 0;

  quaternion_to_euler_angles_unit #(.CORDIC_STAGES(CORDIC_N)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
  );

  always #4 clk = ~clk;

  // watchdog, sized well beyond the slowest correct run
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_CAP) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // floor shift right of a signed value
  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  // vectoring cordic, pi = 2^31 on the internal scale
  function automatic longint vector_angle(longint ys, longint xs);
    longint xv, yv, zv, tmp, xsh, ysh;
    xv = xs;
    yv = ys;
    zv = 0;
    if (xv == 0 && yv == 0) return 0;
    while ((xv < 0 ? -xv : xv) >= NORM_CAP || (yv < 0 ? -yv : yv) >= NORM_CAP) begin
      xv = floor_shift(xv, 1);
      yv = floor_shift(yv, 1);
    end
    // fold left half plane across
    if (xv < 0) begin
      if (yv >= 0) begin
        tmp = xv; xv = yv; yv = -tmp; zv = 64'sd1 <<< 30;
      end else begin
        tmp = xv; xv = -yv; yv = tmp; zv = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xsh = floor_shift(xv, i);
      ysh = floor_shift(yv, i);
      if (yv >= 0) begin
        xv += ysh; yv -= xsh; zv += longint'(atan_val(i));
      end else begin
        xv -= ysh; yv += xsh; zv -= longint'(atan_val(i));
      end
    end
    return zv;
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round half up to a 16-bit binary angle, wrapping pi to -pi
  function automatic logic [15:0] to_binary_angle(longint z);
    longint r;
    r = floor_shift(z + (64'sd1 <<< (31 - ANGLE_BITS)), 32 - ANGLE_BITS);
    return r[15:0];
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                       logic signed [15:0] qy, logic signed [15:0] qz);
    angles_t a;
    longint w, x, y, z, one, half, t, r, p, yw;
    longint unsigned pa, pb;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
    half = 64'sd1 <<< (2 * QUAT_FRAC_BITS - 1);
    r = vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    yw = vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    t = w * y - x * z;
    a.clamp = 1'b0;
    if (t > half) begin t = half; a.clamp = 1'b1; end
    if (t < -half) begin t = -half; a.clamp = 1'b1; end
    pa = longint'(one + 2 * t) << (62 - 2 * QUAT_FRAC_BITS);
    pb = longint'(one - 2 * t) << (62 - 2 * QUAT_FRAC_BITS);
    p = 2 * vector_angle(longint'(floor_root(pa)), longint'(floor_root(pb)))
        - (64'sd1 <<< 30);
    a.roll = to_binary_angle(r);
    a.pitch = to_binary_angle(p);
    a.yaw = to_binary_angle(yw);
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, $signed(got),
             $signed(want), cycle_no);
    fail_count++;
  endtask

  // result checker, one word per done strobe
  always @(posedge clk) begin
    angles_t e;
    if (!rst && done) begin
      if (angles_due.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_no);
        fail_count++;
      end else begin
        e = angles_due.pop_front();
        if (roll_angle !== e.roll) report_mismatch("roll", roll_angle, e.roll);
        if (pitch_angle !== e.pitch) report_mismatch("pitch", pitch_angle, e.pitch);
        if (yaw_angle !== e.yaw) report_mismatch("yaw", yaw_angle, e.yaw);
        if (pitch_clamped !== e.clamp)
          report_mismatch("clamp", 16'(pitch_clamped), 16'(e.clamp));
      end
    end
  end

  // random gap length, mostly short, sometimes long, often none
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    return (r < 92) ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 40));
  endfunction

  // send one word; start stays high across back-to-back words
  task automatic send_word(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, bit gaps);
    int n;
    n = 0;
    if (gaps && $urandom_range(0, 1)) n = gap_cycles();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    angles_due.push_back(euler_of(w, x, y, z));
    n = 0;
    if (gaps && $urandom_range(0, 3) == 0) n = gap_cycles();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
  endtask

  // extremes, axis rotations, zero vector, pi wrap, clamping
  task automatic test_directed();
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    send_word(16'h7FFF, 0, 0, 0, 0);
    send_word(0, 0, 0, 0, 0);
    send_word(0, 16'h7FFF, 0, 0, 0);
    send_word(0, 0, 16'h7FFF, 0, 0);
    send_word(0, 0, 0, 16'h7FFF, 0);
    send_word(16'h5A82, 0, 16'h5A82, 0, 0);
    send_word(16'h5A82, 0, 16'hA57E, 0, 0);
    send_word(16'h7FFF, 0, 16'h7FFF, 0, 0);
    send_word(16'h7FFF, 0, 16'h8000, 0, 0);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_word(16'h4000, 16'h4000, 16'h4000, 16'h4000, 0);
    send_word(16'h4000, 16'hC000, 16'h4000, 16'hC000, 0);
    for (int i = 0; i < 12; i++)
      send_word(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4], ext[(i + 3) % 4], 0);
    drain();
  endtask

  // halved random components mostly, components near +-0.707 or raw noise for the rest
  task automatic test_random(int n);
    logic [15:0] c[4];
    int s;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
        if (s < 6) c[k] = 16'($signed(16'($urandom)) >>> 1);
        else if (s < 8) c[k] = 16'($urandom_range(0, 1) ? 16'h5A82 : 16'hA57E)
                               ^ 16'($urandom_range(0, 255));
        else c[k] = 16'($urandom);
      end
      send_word(c[0], c[1], c[2], c[3], 1);
      // sender holds off once until the pipe has emptied
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1750);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
